>>> rtl/ictn_pkg.sv
// shared types, constants and codes for the item cf top-n recommender
package ictn_pkg;

  localparam int ITEMS       = 256;
  localparam int ID_W        = 8;
  localparam int MAX_TOP_DEF = 64;
  localparam int ACC_W       = 48;
  localparam int NORM_W      = 24;

  // request kinds
  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_HIST   = 3'd1;
  localparam logic [2:0] KIND_TUPLE  = 3'd2;
  localparam logic [2:0] KIND_TOTAL  = 3'd3;
  localparam logic [2:0] KIND_FINISH = 3'd4;

  // configuration register indexes
  localparam logic REG_TOP_N  = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         item_id;
    logic [7:0]         neighbor_id;
    logic signed [15:0] user_score;
    logic signed [15:0] similarity;
    logic signed [31:0] item_total;
  } in_t;

  typedef struct packed {
    logic [7:0]         rec_item;
    logic signed [31:0] rank_score;
    logic               is_last;
    logic               is_empty;
    logic               from_cold_start;
  } out_t;

  // one ranked entry held or passed along the chain
  typedef struct packed {
    logic               vld;
    logic signed [31:0] score;
    logic [ID_W-1:0]    id;
  } entry_t;

  // control shared by all chain cells
  typedef struct packed {
    logic clr;
    logic pop;
  } cell_ctrl_t;

endpackage

>>> rtl/ictn_ram.sv
// generic single write port ram with registered read
module ictn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ictn_div.sv
// bit-serial signed by unsigned divider with 32-bit saturation
module ictn_div import ictn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic signed [ACC_W-1:0]  dividend,
  input  logic [NORM_W-1:0]        divisor,
  output logic                     done,
  output logic signed [31:0]       quot
);

  localparam int CW = $clog2(ACC_W + 1);

  logic [NORM_W:0]   rem_r;
  logic [ACC_W-1:0]  quo_r;
  logic [NORM_W-1:0] dvs_r;
  logic              neg_r;
  logic [CW-1:0]     cnt_r;
  logic              run_r;
  logic              done_r;
  logic [NORM_W:0]   shl;
  logic [NORM_W:0]   diff;
  logic              fits;

  // one quotient bit per cycle
  assign shl  = {rem_r[NORM_W-1:0], quo_r[ACC_W-1]};
  assign diff = shl - {1'b0, dvs_r};
  assign fits = shl >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CW'(ACC_W);
        rem_r <= '0;
        dvs_r <= divisor;
        neg_r <= dividend[ACC_W-1];
        quo_r <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
      end else if (run_r) begin
        rem_r <= fits ? diff : shl;
        quo_r <= {quo_r[ACC_W-2:0], fits};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // sign and saturate the magnitude quotient
  always_comb begin
    if (!neg_r) begin
      quot = (quo_r > ACC_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo_r[31:0]);
    end else begin
      quot = (quo_r > ACC_W'(33'h0_8000_0000)) ? 32'sh8000_0000 :
             $signed(-quo_r[31:0]);
    end
  end

  assign done = done_r;

endmodule

>>> rtl/ictn_cell.sv
// one cell of the sorted top-n chain: keeps the better entry, passes the other
module ictn_cell import ictn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  entry_t     cand_in,
  input  entry_t     nbr_hold,
  output entry_t     pass_out,
  output entry_t     hold
);

  entry_t hold_r;
  entry_t pass_r;
  logic   better;

  // higher score wins, equal score goes to the lower id
  assign better = (cand_in.score > hold_r.score) ||
                  ((cand_in.score == hold_r.score) && (cand_in.id < hold_r.id));

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      hold_r.vld <= 1'b0;
      pass_r.vld <= 1'b0;
    end else if (ctrl.pop) begin
      hold_r     <= nbr_hold;
      pass_r.vld <= 1'b0;
    end else if (cand_in.vld) begin
      if (!hold_r.vld) begin
        hold_r     <= cand_in;
        pass_r.vld <= 1'b0;
      end else if (better) begin
        hold_r <= cand_in;
        pass_r <= hold_r;
      end else begin
        pass_r <= cand_in;
      end
    end else begin
      pass_r.vld <= 1'b0;
    end
  end

  assign hold     = hold_r;
  assign pass_out = pass_r;

endmodule

>>> rtl/item_cf_top_n_recommend_unit.sv
// top level of the item cf top-n recommender
//
// Usage: a request is taken on a clk edge with start high and busy low; its
// fields arrive on in_data. Clear, history and item-total requests finish in
// the cycle they are taken and busy stays low. A neighbor tuple reads the
// history score and the neighbor's accumulators, multiplies, then writes back:
// busy is high through ST_TMUL and ST_TACC, so no tuple is taken until the
// last one is written back. A finish request walks all ITEMS entries; per
// entry the tables are read, and the bit-serial 48/24 divider runs when
// the entry is a candidate (cold start needs no divide). Candidates enter
// a chain of MAX_TOP sorting cells, one cell step per cycle; after the walk
// the chain settles, then results leave cell 0 one per cycle on out_valid /
// out_data, best first, the last flagged by is_last. A run with nothing to
// show gives a single result with is_empty and is_last set.
// Results cannot be held off; each one is on the ports for one cycle.
// Configuration writes on cfg_we / cfg_addr / cfg_wdata take effect at once.
// Reset clears the history and accumulator marks, item-total marks and sets
// top_n to 10 and the threshold to 0; no clearing pass is needed.
module item_cf_top_n_recommend_unit import ictn_pkg::*; #(
  parameter int MAX_TOP = MAX_TOP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int DW = $clog2(MAX_TOP + 3);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_TMUL  = 8'b0000_0010,
    ST_TACC  = 8'b0000_0100,
    ST_FRD   = 8'b0000_1000,
    ST_FEVAL = 8'b0001_0000,
    ST_FDIV  = 8'b0010_0000,
    ST_FDRN  = 8'b0100_0000,
    ST_FOUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]         top_n_r;
  logic signed [15:0] thr_r;
  logic [ITEMS-1:0]   seen_r;
  logic [ITEMS-1:0]   touched_r;
  logic [ITEMS-1:0]   present_r;
  logic               nonempty_r;
  logic               cold_r;

  logic               acc_go;
  logic [ID_W-1:0]    nbr_r;
  logic signed [15:0] sim_r;
  logic               pre_r;
  logic               cond_r;
  logic signed [31:0] prod_r;
  logic [ID_W-1:0]    idx_r;
  logic [DW-1:0]      drn_r;
  logic [6:0]         cnt_r;
  entry_t             cand_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic signed [15:0]       hist_rd;
  logic signed [ACC_W-1:0]  ws_rd;
  logic [NORM_W-1:0]        wn_rd;
  logic signed [31:0]       tot_rd;
  logic [ID_W-1:0]          ws_raddr;
  logic signed [ACC_W-1:0]  ws_old;
  logic [NORM_W-1:0]        wn_old;
  logic signed [ACC_W:0]    acc_sum;
  logic signed [ACC_W-1:0]  acc_sat;
  logic [NORM_W:0]          nrm_sum;
  logic [NORM_W-1:0]        nrm_sat;
  logic [15:0]              sim_mag;
  logic                     ws_we;
  logic [6:0]               limit;
  logic                     last_idx;
  logic                     warm_ok;
  logic                     div_go;
  logic                     div_done;
  logic signed [31:0]       div_q;
  logic                     emit_empty;
  logic                     emit_last;
  cell_ctrl_t               cctl;
  entry_t                   hold_a [MAX_TOP+1];
  entry_t                   pass_a [MAX_TOP+1];

  assign busy   = (state_r != ST_IDLE);
  assign acc_go = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_n_r <= 7'd10;
      thr_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TOP_N:  top_n_r <= cfg_wdata[6:0];
        REG_THRESH: thr_r   <= $signed(cfg_wdata);
        default:    ;
      endcase
    end
  end

  // per-item marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      touched_r  <= '0;
      present_r  <= '0;
      nonempty_r <= 1'b0;
    end else begin
      if (acc_go && in_data.kind == KIND_CLEAR) begin
        seen_r     <= '0;
        touched_r  <= '0;
        nonempty_r <= 1'b0;
      end
      if (acc_go && in_data.kind == KIND_HIST) begin
        seen_r[in_data.item_id] <= 1'b1;
        nonempty_r              <= 1'b1;
      end
      if (acc_go && in_data.kind == KIND_TOTAL) begin
        present_r[in_data.item_id] <= 1'b1;
      end
      if (ws_we) begin
        touched_r[nbr_r] <= 1'b1;
      end
    end
  end

  // tables
  assign ws_raddr = (state_r == ST_IDLE) ? in_data.neighbor_id :
                    ((state_r == ST_TMUL) || (state_r == ST_TACC)) ? nbr_r : idx_r;
  assign ws_we    = (state_r == ST_TACC) && cond_r;

  ictn_ram #(.WIDTH(16), .DEPTH(ITEMS)) u_hist (
    .clk, .we(acc_go && in_data.kind == KIND_HIST), .waddr(in_data.item_id),
    .wdata(in_data.user_score), .raddr(in_data.item_id), .rdata(hist_rd)
  );

  ictn_ram #(.WIDTH(ACC_W), .DEPTH(ITEMS)) u_wsum (
    .clk, .we(ws_we), .waddr(nbr_r), .wdata(acc_sat), .raddr(ws_raddr), .rdata(ws_rd)
  );

  ictn_ram #(.WIDTH(NORM_W), .DEPTH(ITEMS)) u_wnorm (
    .clk, .we(ws_we), .waddr(nbr_r), .wdata(nrm_sat), .raddr(ws_raddr), .rdata(wn_rd)
  );

  ictn_ram #(.WIDTH(32), .DEPTH(ITEMS)) u_total (
    .clk, .we(acc_go && in_data.kind == KIND_TOTAL), .waddr(in_data.item_id),
    .wdata(in_data.item_total), .raddr(idx_r), .rdata(tot_rd)
  );

  // accumulate with saturation; untouched entries read as zero
  assign ws_old  = touched_r[nbr_r] ? ws_rd : '0;
  assign wn_old  = touched_r[nbr_r] ? wn_rd : '0;
  assign acc_sum = (ACC_W+1)'(ws_old) + (ACC_W+1)'(prod_r);
  assign sim_mag = sim_r[15] ? 16'(-sim_r) : 16'(sim_r);
  assign nrm_sum = {1'b0, wn_old} + (NORM_W+1)'(sim_mag);
  assign nrm_sat = nrm_sum[NORM_W] ? {NORM_W{1'b1}} : nrm_sum[NORM_W-1:0];

  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  // finish helpers
  assign limit    = (top_n_r > 7'(MAX_TOP)) ? 7'(MAX_TOP) : top_n_r;
  assign last_idx = (idx_r == ID_W'(ITEMS - 1));
  assign warm_ok  = touched_r[idx_r] && !seen_r[idx_r] && (wn_rd != '0);
  assign div_go   = (state_r == ST_FEVAL) && !cold_r && warm_ok;

  ictn_div u_div (
    .clk, .rst_n, .go(div_go), .dividend(ws_rd), .divisor(wn_rd),
    .done(div_done), .quot(div_q)
  );

  assign emit_empty = (cnt_r == '0) && ((limit == '0) || !hold_a[0].vld);
  assign emit_last  = emit_empty || (cnt_r + 7'd1 == limit) || !hold_a[1].vld;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_go && in_data.kind == KIND_TUPLE) state_nxt = ST_TMUL;
        else if (acc_go && in_data.kind == KIND_FINISH) state_nxt = ST_FRD;
      end
      ST_TMUL:  state_nxt = ST_TACC;
      ST_TACC:  state_nxt = ST_IDLE;
      ST_FRD:   state_nxt = ST_FEVAL;
      ST_FEVAL: begin
        if (div_go) state_nxt = ST_FDIV;
        else state_nxt = last_idx ? ST_FDRN : ST_FRD;
      end
      ST_FDIV: begin
        if (div_done) state_nxt = last_idx ? ST_FDRN : ST_FRD;
      end
      ST_FDRN: begin
        if (drn_r == '0) state_nxt = ST_FOUT;
      end
      ST_FOUT: begin
        if (emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r.vld  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cand_r.vld  <= 1'b0;
      out_valid_r <= 1'b0;
      if (acc_go) begin
        nbr_r <= in_data.neighbor_id;
        sim_r <= in_data.similarity;
        pre_r <= seen_r[in_data.item_id] && !seen_r[in_data.neighbor_id];
        idx_r <= '0;
        cold_r <= (in_data.kind == KIND_FINISH) ? !nonempty_r : cold_r;
      end
      if (state_r == ST_TMUL) begin
        cond_r <= pre_r && (hist_rd >= thr_r);
        prod_r <= sim_r * hist_rd;
      end
      if (state_r == ST_FEVAL) begin
        if (cold_r && present_r[idx_r]) begin
          cand_r.vld   <= 1'b1;
          cand_r.score <= tot_rd;
          cand_r.id    <= idx_r;
        end
        if (!div_go && !last_idx) idx_r <= idx_r + ID_W'(1);
      end
      if (state_r == ST_FDIV && div_done) begin
        cand_r.vld   <= 1'b1;
        cand_r.score <= div_q;
        cand_r.id    <= idx_r;
        if (!last_idx) idx_r <= idx_r + ID_W'(1);
      end
      if (state_nxt == ST_FDRN && state_r != ST_FDRN) begin
        drn_r <= DW'(MAX_TOP + 2);
      end else if (state_r == ST_FDRN) begin
        drn_r <= drn_r - DW'(1);
      end
      if (state_r == ST_FDRN) cnt_r <= '0;
      if (state_r == ST_FOUT) begin
        out_valid_r                <= 1'b1;
        out_data_r.rec_item        <= emit_empty ? '0 : hold_a[0].id;
        out_data_r.rank_score      <= emit_empty ? '0 : hold_a[0].score;
        out_data_r.is_last         <= emit_last;
        out_data_r.is_empty        <= emit_empty;
        out_data_r.from_cold_start <= cold_r;
        cnt_r                      <= cnt_r + 7'd1;
      end
    end
  end

  // sorting chain
  assign cctl.clr = acc_go && in_data.kind == KIND_FINISH;
  assign cctl.pop = (state_r == ST_FOUT) && !emit_empty;
  assign pass_a[0]       = cand_r;
  assign hold_a[MAX_TOP] = '0;

  for (genvar k = 0; k < MAX_TOP; k++) begin : g_cell
    ictn_cell u_cell (
      .clk, .rst_n, .ctrl(cctl), .cand_in(pass_a[k]), .nbr_hold(hold_a[k+1]),
      .pass_out(pass_a[k+1]), .hold(hold_a[k])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/ictn_chk.sv
// port-level checker for the recommender, bound to the top level
module ictn_chk import ictn_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  // results appear only right after a busy cycle
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without finish run");

  // an empty run is a single, last result
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_empty) |-> out_data.is_last)
    else $error("empty result not last");

  // empty result carries zero payload
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_empty) |->
      (out_data.rec_item == '0 && out_data.rank_score == '0))
    else $error("empty result has payload");

  // finish request makes the block busy
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.kind == KIND_FINISH) |=> busy)
    else $error("finish not started");

endmodule

bind item_cf_top_n_recommend_unit ictn_chk u_ictn_chk (.*);

>>> bench/item_cf_top_n_recommend_unit_tb.sv
// testbench for the item cf top-n recommender: directed and random requests, scoreboard check
`timescale 1ns / 100ps

module item_cf_top_n_recommend_unit_tb;
  import ictn_pkg::*;

  localparam int WD_LIMIT = 60000;
  localparam int N_IDS    = 256;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;

  item_cf_top_n_recommend_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // predictor state: user history, accumulators and item totals
  bit              seen[N_IDS];
  int              hist_score[N_IDS];
  longint          wsum[N_IDS];
  longint          wnorm[N_IDS];
  bit              touched[N_IDS];
  int              totals[N_IDS];
  bit              total_ok[N_IDS];
  bit              has_history;
  int              top_n_reg;
  int              thresh_reg;

  out_t            recs_q[$];
  int              errors = 0;
  int              idle_pct = 0;
  int              wd_count = 0;

  // report one mismatch and count it
  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void clear_user();
    for (int i = 0; i < N_IDS; i++) begin
      seen[i] = 0;
      wsum[i] = 0;
      wnorm[i] = 0;
      touched[i] = 0;
    end
    has_history = 0;
  endfunction

  // rank candidates and queue the recommendations a finish produces
  function automatic void rank_and_queue();
    bit     ok[N_IDS];
    longint cand[N_IDS];
    bit     cold;
    int     lim;
    int     n;
    int     best;
    out_t   o;
    cold = !has_history;
    lim = (top_n_reg > 64) ? 64 : top_n_reg;
    n = 0;
    for (int i = 0; i < N_IDS; i++) begin
      if (cold) begin
        ok[i] = total_ok[i];
        cand[i] = totals[i];
      end else begin
        ok[i] = touched[i] && !seen[i] && wnorm[i] != 0;
        cand[i] = 0;
        if (ok[i]) begin
          cand[i] = wsum[i] / wnorm[i];
          if (cand[i] > 64'sd2147483647) cand[i] = 64'sd2147483647;
          if (cand[i] < -64'sd2147483648) cand[i] = -64'sd2147483648;
        end
      end
    end
    while (n < lim) begin
      best = -1;
      for (int i = 0; i < N_IDS; i++)
        if (ok[i] && (best < 0 || cand[i] > cand[best])) best = i;
      if (best < 0) break;
      ok[best] = 0;
      o = '0;
      o.rec_item = best[7:0];
      o.rank_score = cand[best][31:0];
      o.from_cold_start = cold;
      recs_q.push_back(o);
      n++;
    end
    if (n == 0) begin
      o = '0;
      o.is_last = 1'b1;
      o.is_empty = 1'b1;
      o.from_cold_start = cold;
      recs_q.push_back(o);
    end else begin
      recs_q[recs_q.size() - 1].is_last = 1'b1;
    end
  endfunction

  // update predictor state for one accepted request
  function automatic void predict(input in_t r);
    longint acc;
    longint mag;
    case (r.kind)
      KIND_CLEAR: clear_user();
      KIND_HIST: begin
        seen[r.item_id] = 1;
        hist_score[r.item_id] = r.user_score;
        has_history = 1;
      end
      KIND_TUPLE: begin
        if (seen[r.item_id] && hist_score[r.item_id] >= thresh_reg && !seen[r.neighbor_id]) begin
          acc = wsum[r.neighbor_id] + longint'(r.similarity) * hist_score[r.item_id];
          mag = (r.similarity < 0) ? -longint'(r.similarity) : longint'(r.similarity);
          if (acc > 64'sd140737488355327) acc = 64'sd140737488355327;
          if (acc < -64'sd140737488355328) acc = -64'sd140737488355328;
          wsum[r.neighbor_id] = acc;
          wnorm[r.neighbor_id] = wnorm[r.neighbor_id] + mag;
          if (wnorm[r.neighbor_id] > 16777215) wnorm[r.neighbor_id] = 16777215;
          touched[r.neighbor_id] = 1;
        end
      end
      KIND_TOTAL: begin
        totals[r.item_id] = r.item_total;
        total_ok[r.item_id] = 1;
      end
      KIND_FINISH: rank_and_queue();
      default: ;
    endcase
  endfunction

  function automatic in_t mk(input logic [2:0] k, input int id, input int nb,
                             input int sc, input int sim, input int tot);
    in_t r;
    r.kind = k;
    r.item_id = id[7:0];
    r.neighbor_id = nb[7:0];
    r.user_score = sc[15:0];
    r.similarity = sim[15:0];
    r.item_total = tot;
    return r;
  endfunction

  // send one request and wait until the block takes it
  task automatic send_req(input in_t r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    predict(r);
  endtask

  // drain results and let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    while (recs_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TOP_N) top_n_reg = val & 127;
    else thresh_reg = int'($signed(val[15:0]));
  endtask

  // result checker against the oldest expected recommendation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (recs_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        out_t e;
        e = recs_q.pop_front();
        if (out_data.rec_item !== e.rec_item)
          report($sformatf("rec_item %0d exp %0d", out_data.rec_item, e.rec_item));
        if (out_data.rank_score !== e.rank_score)
          report($sformatf("rank_score %0d exp %0d item %0d",
                           out_data.rank_score, e.rank_score, e.rec_item));
        if (out_data.is_last !== e.is_last)
          report($sformatf("is_last %b exp %b", out_data.is_last, e.is_last));
        if (out_data.is_empty !== e.is_empty)
          report($sformatf("is_empty %b exp %b", out_data.is_empty, e.is_empty));
        if (out_data.from_cold_start !== e.from_cold_start)
          report($sformatf("from_cold_start %b exp %b",
                           out_data.from_cold_start, e.from_cold_start));
      end
    end
  end

  // watchdog on cycles with no request, result or register write
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) wd_count <= 0;
    else wd_count <= wd_count + 1;
    if (wd_count >= WD_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // extremes, every kind and the special cases
  task automatic test_directed();
    idle_pct = 0;
    send_req(mk(KIND_FINISH, 0, 0, 0, 0, 0));                 // nothing loaded, cold
    send_req(mk(KIND_TOTAL, 0, 0, 0, 0, 32'h7fffffff));
    send_req(mk(KIND_TOTAL, 255, 255, 0, 0, 32'h80000000));
    send_req(mk(KIND_TOTAL, 7, 0, 0, 0, 32'h7fffffff));       // tie with item 0
    send_req(mk(3'd5, 9, 9, -1, -1, -1));                     // unknown kinds
    send_req(mk(3'd6, 0, 0, 0, 0, 0));
    send_req(mk(3'd7, 255, 255, 32767, 32767, 1));
    send_req(mk(KIND_FINISH, 255, 255, -1, -1, -1));
    send_req(mk(KIND_CLEAR, 0, 0, 0, 0, 0));
    send_req(mk(KIND_HIST, 1, 0, 32767, 0, 0));
    send_req(mk(KIND_HIST, 2, 0, -32768, 0, 0));
    send_req(mk(KIND_HIST, 3, 0, 100, 0, 0));
    send_req(mk(KIND_HIST, 3, 0, 256, 0, 0));                 // overwrite score
    send_req(mk(KIND_TUPLE, 1, 10, 0, 32767, 0));
    send_req(mk(KIND_TUPLE, 3, 10, 0, -32768, 0));
    send_req(mk(KIND_TUPLE, 2, 11, 0, -32768, 0));            // below threshold
    send_req(mk(KIND_TUPLE, 3, 1, 0, 5000, 0));               // neighbor already seen
    send_req(mk(KIND_TUPLE, 9, 12, 0, 5000, 0));              // source not seen
    send_req(mk(KIND_TUPLE, 3, 13, 0, 0, 0));                 // zero norm
    send_req(mk(KIND_TUPLE, 1, 14, 0, 1, 0));
    send_req(mk(KIND_TUPLE, 3, 15, 0, -1, 0));
    send_req(mk(KIND_HIST, 14, 0, 0, 0, 0));                  // neighbor seen later
    send_req(mk(KIND_FINISH, 0, 0, 0, 0, 0));
  endtask

  // register extremes: no output, oversize top_n, threshold range
  task automatic test_config();
    write_reg(REG_TOP_N, 0);
    send_req(mk(KIND_FINISH, 0, 0, 0, 0, 0));
    write_reg(REG_TOP_N, 127);
    write_reg(REG_THRESH, -32768);
    send_req(mk(KIND_TUPLE, 2, 11, 0, -32768, 0));
    send_req(mk(KIND_FINISH, 0, 0, 0, 0, 0));
    write_reg(REG_THRESH, 32767);
    send_req(mk(KIND_TUPLE, 1, 20, 0, 700, 0));
    send_req(mk(KIND_FINISH, 0, 0, 0, 0, 0));
    write_reg(REG_TOP_N, 1);
    write_reg(REG_THRESH, 0);
    send_req(mk(KIND_FINISH, 0, 0, 0, 0, 0));
    write_reg(REG_TOP_N, 64);
  endtask

  // one user session: clear, history, tuples, totals, finish, some noise
  task automatic run_session();
    int hist_ids[$];
    int nh;
    int nt;
    int id;
    send_req(mk(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
    nh = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 5);
    for (int i = 0; i < nh; i++) begin
      id = $urandom_range(15);
      hist_ids.push_back(id);
      send_req(mk(KIND_HIST, id, $urandom, $urandom, $urandom, $urandom));
    end
    nt = $urandom_range(3, 8);
    for (int i = 0; i < nt; i++) begin
      case ($urandom_range(9))
        0: send_req(mk(KIND_TOTAL, $urandom_range(31), $urandom, $urandom, $urandom, $urandom));
        1: send_req(mk($urandom_range(7) == 4 ? 3'd5 : 3'($urandom_range(7)),
                       $urandom, $urandom, $urandom, $urandom, $urandom));
        default: begin
          id = (hist_ids.size() != 0 && $urandom_range(4) != 0) ?
               hist_ids[$urandom_range(hist_ids.size() - 1)] : $urandom_range(15);
          send_req(mk(KIND_TUPLE, id, $urandom_range(23), $urandom, $urandom, $urandom));
        end
      endcase
    end
    send_req(mk(KIND_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic test_random(input int pct);
    idle_pct = pct;
    write_reg(REG_TOP_N, ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 12));
    write_reg(REG_THRESH, ($urandom_range(1) == 0) ? 0 : $urandom_range(65535));
    repeat (2) run_session();
  endtask

  initial begin
    top_n_reg = 10;
    thresh_reg = 0;
    clear_user();
    for (int i = 0; i < N_IDS; i++) begin
      hist_score[i] = 0;
      totals[i] = 0;
      total_ok[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config();
    test_random(0);
    test_random(61);
    test_random(31);
    test_random(0);
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> item_cf_top_n_recommend_unit.f
rtl/ictn_pkg.sv
rtl/ictn_ram.sv
rtl/ictn_div.sv
rtl/ictn_cell.sv
rtl/item_cf_top_n_recommend_unit.sv
rtl/ictn_chk.sv
bench/item_cf_top_n_recommend_unit_tb.sv
